[rtl/imq_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed max priority queue package
// Shared sizes, codes, state and command types for the heap controller and
// datapath.
// ----------------------------------------------------------------------------
package imq_pkg;

   localparam int CAPACITY = 256;
   localparam int KEY_BITS = 32;
   localparam int IDX_BITS = 8;
   localparam int POS_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int OP_BITS = 2;
   localparam int STATUS_BITS = 3;
   localparam int REQ_KEY_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_EXTRACT = 2'd2,
      OP_CHANGE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_PRESENT = 3'd1,
      STATUS_ABSENT  = 3'd2,
      STATUS_EMPTY   = 3'd3,
      STATUS_FULL    = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_INS, S_REM, S_EXT, S_EXT_B, S_CHG, S_CHG_B,
      S_TO_A, S_TO_B, S_TO_C, S_UP_A, S_UP_B, S_UP_C,
      S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_FIN, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LATCH, CMD_ERR, CMD_INS, CMD_CHG_RD, CMD_CHG_WR,
      CMD_EX_RD, CMD_EX_TAKE, CMD_TO_A, CMD_TO_B, CMD_TO_C,
      CMD_UP_RD, CMD_UP_KEY, CMD_UP_SWAP, CMD_DN_RD, CMD_DN_B, CMD_DN_C,
      CMD_DN_SWAP, CMD_FIN, CMD_LOAD
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      status_type err;
   } ctrl_cmd_type;

   typedef struct packed {
      logic inrange;
      logic here;
      logic cnt_zero;
      logic i_zero;
      logic key_gt;
      logic take_sift;
      logic last_gt;
      logic up_gt;
      logic dn_move;
   } dp_status_type;

endpackage

[rtl/imq_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed max priority queue controller
// Sequences each request through the heap datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module imq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [imq_pkg::OP_BITS-1:0] req_op,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  imq_pkg::dp_status_type    st,
   output imq_pkg::ctrl_cmd_type     cmd
);
   import imq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = CMD_NONE;
      cmd.err   = STATUS_OK;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = CMD_LATCH;
               case (op_type'(req_op))
                  OP_INSERT:  state_in = S_INS;
                  OP_REMOVE:  state_in = S_REM;
                  OP_EXTRACT: state_in = S_EXT;
                  default:    state_in = S_CHG;
               endcase
            end
         end
         S_INS: begin
            if (!st.inrange) begin
               cmd.op = CMD_ERR;
               cmd.err = STATUS_FULL;
               state_in = S_DONE;
            end else if (st.here) begin
               cmd.op = CMD_ERR;
               cmd.err = STATUS_PRESENT;
               state_in = S_DONE;
            end else begin
               cmd.op = CMD_INS;
               state_in = S_UP_A;
            end
         end
         S_REM: begin
            if (!st.inrange || !st.here) begin
               cmd.op = CMD_ERR;
               cmd.err = STATUS_ABSENT;
               state_in = S_DONE;
            end else begin
               state_in = S_TO_A;
            end
         end
         S_EXT: begin
            if (st.cnt_zero) begin
               cmd.op = CMD_ERR;
               cmd.err = STATUS_EMPTY;
               state_in = S_DONE;
            end else begin
               cmd.op = CMD_EX_RD;
               state_in = S_EXT_B;
            end
         end
         S_EXT_B: begin
            cmd.op = CMD_EX_TAKE;
            state_in = S_TO_A;
         end
         S_CHG: begin
            if (!st.inrange || !st.here) begin
               cmd.op = CMD_ERR;
               cmd.err = STATUS_ABSENT;
               state_in = S_DONE;
            end else begin
               cmd.op = CMD_CHG_RD;
               state_in = S_CHG_B;
            end
         end
         S_CHG_B: begin
            cmd.op = CMD_CHG_WR;
            state_in = st.key_gt ? S_UP_A : S_DN_A;
         end
         S_TO_A: begin
            cmd.op = CMD_TO_A;
            state_in = S_TO_B;
         end
         S_TO_B: begin
            cmd.op = CMD_TO_B;
            state_in = S_TO_C;
         end
         S_TO_C: begin
            cmd.op = CMD_TO_C;
            if (st.take_sift) begin
               state_in = st.last_gt ? S_UP_A : S_DN_A;
            end else begin
               state_in = S_FIN;
            end
         end
         S_UP_A: begin
            if (st.i_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.op = CMD_UP_RD;
               state_in = S_UP_B;
            end
         end
         S_UP_B: begin
            cmd.op = CMD_UP_KEY;
            state_in = S_UP_C;
         end
         S_UP_C: begin
            if (st.up_gt) begin
               cmd.op = CMD_UP_SWAP;
               state_in = S_UP_A;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_A: begin
            cmd.op = CMD_DN_RD;
            state_in = S_DN_B;
         end
         S_DN_B: begin
            cmd.op = CMD_DN_B;
            state_in = S_DN_C;
         end
         S_DN_C: begin
            cmd.op = CMD_DN_C;
            state_in = S_DN_D;
         end
         S_DN_D: begin
            if (st.dn_move) begin
               cmd.op = CMD_DN_SWAP;
               state_in = S_DN_A;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.op = CMD_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = CMD_LOAD;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/imq_dp.sv]
// ----------------------------------------------------------------------------
// Indexed max priority queue datapath
// Heap memories, valid bits, sift registers and the result register.
// ----------------------------------------------------------------------------
module imq_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  imq_pkg::ctrl_cmd_type           cmd,
   input  logic [imq_pkg::IDX_BITS-1:0]     req_entry_index,
   input  logic [imq_pkg::REQ_KEY_BITS-1:0] req_priority_key,
   output imq_pkg::dp_status_type          st,
   output logic [imq_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [imq_pkg::IDX_BITS-1:0]     rsp_result_index,
   output logic                            rsp_present,
   output logic                            rsp_is_empty,
   output logic [imq_pkg::CNT_BITS-1:0]     rsp_occupancy
);
   import imq_pkg::*;

   logic [IDX_BITS-1:0] idx_mem [CAPACITY];
   logic [POS_BITS-1:0] pos_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [IDX_BITS-1:0] idx_rd_ff;
   logic [POS_BITS-1:0] pos_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [CAPACITY-1:0] valid_ff;

   logic [IDX_BITS-1:0]    idx_ff, t_ff, sidx_ff, up_ff, il_ff, ir_ff;
   logic [KEY_BITS-1:0]    key_ff, skey_ff, aux_key_ff, kl_ff;
   logic [POS_BITS-1:0]    i_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   status_type             status_ff;
   logic [IDX_BITS-1:0]    res_ff;
   logic                   pres_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [IDX_BITS-1:0]    rsp_result_index_ff;
   logic                   rsp_present_ff, rsp_is_empty_ff;
   logic [CNT_BITS-1:0]    rsp_occupancy_ff;

   logic [POS_BITS-1:0] idx_raddr, idx_waddr, pos_wdata;
   logic [IDX_BITS-1:0] key_raddr, pos_raddr, pos_waddr, idx_wdata, key_waddr;
   logic                idx_we, pos_we, key_we;
   logic [POS_BITS-1:0] parent;
   logic [POS_BITS:0]   left_pos;
   logic [POS_BITS+1:0] right_pos;
   logic                left_ok, right_ok, left_win, right_win;
   logic [KEY_BITS-1:0] best_key;
   logic [POS_BITS-1:0] best_pos;
   logic [IDX_BITS-1:0] best_idx;

   assign parent    = POS_BITS'((i_ff - POS_BITS'(1)) >> 1);
   assign left_pos  = {i_ff, 1'b1};
   assign right_pos = (POS_BITS+2)'({i_ff, 1'b0}) + (POS_BITS+2)'(2);
   assign left_ok   = (POS_BITS+2)'(left_pos) < (POS_BITS+2)'(cnt_ff);
   assign right_ok  = right_pos < (POS_BITS+2)'(cnt_ff);
   assign left_win  = left_ok && (kl_ff > skey_ff);
   assign best_key  = left_win ? kl_ff : skey_ff;
   assign right_win = right_ok && (key_rd_ff > best_key);
   assign best_pos  = right_win ? right_pos[POS_BITS-1:0] : left_pos[POS_BITS-1:0];
   assign best_idx  = right_win ? ir_ff : il_ff;

   assign st.inrange   = CNT_BITS'(idx_ff) < CNT_BITS'(CAPACITY);
   assign st.here      = valid_ff[idx_ff[POS_BITS-1:0]];
   assign st.cnt_zero  = (cnt_ff == '0);
   assign st.i_zero    = (i_ff == '0);
   assign st.key_gt    = key_ff > key_rd_ff;
   assign st.take_sift = (cnt_ff > CNT_BITS'(1)) && (sidx_ff != t_ff);
   assign st.last_gt   = key_rd_ff > aux_key_ff;
   assign st.up_gt     = skey_ff > key_rd_ff;
   assign st.dn_move   = left_win || right_win;

   always_comb begin
      idx_raddr = '0;
      key_raddr = '0;
      pos_raddr = '0;
      idx_we    = 1'b0;
      idx_waddr = i_ff;
      idx_wdata = sidx_ff;
      pos_we    = 1'b0;
      pos_waddr = sidx_ff;
      pos_wdata = i_ff;
      key_we    = 1'b0;
      key_waddr = idx_ff;
      unique case (cmd.op) inside
         CMD_INS, CMD_CHG_WR: key_we = 1'b1;
         CMD_CHG_RD: begin
            key_raddr = idx_ff;
            pos_raddr = idx_ff;
         end
         CMD_EX_RD: idx_raddr = '0;
         CMD_TO_A: begin
            idx_raddr = POS_BITS'(cnt_ff - CNT_BITS'(1));
            key_raddr = t_ff;
            pos_raddr = t_ff;
         end
         CMD_TO_B, CMD_UP_KEY, CMD_DN_C: key_raddr = idx_rd_ff;
         CMD_UP_RD: idx_raddr = parent;
         CMD_DN_RD: idx_raddr = left_pos[POS_BITS-1:0];
         CMD_DN_B: begin
            key_raddr = idx_rd_ff;
            idx_raddr = right_pos[POS_BITS-1:0];
         end
         CMD_UP_SWAP: begin
            idx_we = 1'b1;
            idx_wdata = up_ff;
            pos_we = 1'b1;
            pos_waddr = up_ff;
         end
         CMD_DN_SWAP: begin
            idx_we = 1'b1;
            idx_wdata = best_idx;
            pos_we = 1'b1;
            pos_waddr = best_idx;
         end
         CMD_FIN: begin
            idx_we = 1'b1;
            pos_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_rd_ff <= idx_mem[idx_raddr];
      pos_rd_ff <= pos_mem[pos_raddr[POS_BITS-1:0]];
      key_rd_ff <= key_mem[key_raddr[POS_BITS-1:0]];
      if (idx_we) begin
         idx_mem[idx_waddr] <= idx_wdata;
      end
      if (pos_we) begin
         pos_mem[pos_waddr[POS_BITS-1:0]] <= pos_wdata;
      end
      if (key_we) begin
         key_mem[key_waddr[POS_BITS-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (cmd.op)
            CMD_INS: begin
               valid_ff[idx_ff[POS_BITS-1:0]] <= 1'b1;
               cnt_ff <= cnt_ff + CNT_BITS'(1);
            end
            CMD_TO_A: begin
               valid_ff[t_ff[POS_BITS-1:0]] <= 1'b0;
               cnt_ff <= cnt_ff - CNT_BITS'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CMD_LATCH: begin
            idx_ff    <= req_entry_index;
            t_ff      <= req_entry_index;
            key_ff    <= req_priority_key[KEY_BITS-1:0];
            status_ff <= STATUS_OK;
            res_ff    <= req_entry_index;
            pres_ff   <= 1'b0;
         end
         CMD_ERR: begin
            status_ff <= cmd.err;
            pres_ff   <= (cmd.err == STATUS_PRESENT);
            if (cmd.err == STATUS_EMPTY) begin
               res_ff <= '0;
            end
         end
         CMD_INS: begin
            sidx_ff <= idx_ff;
            skey_ff <= key_ff;
            i_ff    <= POS_BITS'(cnt_ff);
            pres_ff <= 1'b1;
         end
         CMD_CHG_RD: pres_ff <= 1'b1;
         CMD_CHG_WR: begin
            sidx_ff <= idx_ff;
            skey_ff <= key_ff;
            i_ff    <= pos_rd_ff;
         end
         CMD_EX_TAKE: begin
            t_ff   <= idx_rd_ff;
            res_ff <= idx_rd_ff;
         end
         CMD_TO_B: begin
            i_ff       <= pos_rd_ff;
            sidx_ff    <= idx_rd_ff;
            aux_key_ff <= key_rd_ff;
         end
         CMD_TO_C: skey_ff <= key_rd_ff;
         CMD_UP_KEY: up_ff <= idx_rd_ff;
         CMD_UP_SWAP: i_ff <= parent;
         CMD_DN_B: il_ff <= idx_rd_ff;
         CMD_DN_C: begin
            kl_ff <= key_rd_ff;
            ir_ff <= idx_rd_ff;
         end
         CMD_DN_SWAP: i_ff <= best_pos;
         CMD_LOAD: begin
            rsp_status_ff       <= status_ff;
            rsp_result_index_ff <= res_ff;
            rsp_present_ff      <= pres_ff;
            rsp_is_empty_ff     <= (cnt_ff == '0);
            rsp_occupancy_ff    <= cnt_ff;
         end
         default: ;
      endcase
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_result_index_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_is_empty     = rsp_is_empty_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_ins_absent: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_INS) |-> !valid_ff[idx_ff[POS_BITS-1:0]])
      else $error("Insert of an index that is already present.");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_TO_A) |-> (cnt_ff != '0) && valid_ff[t_ff[POS_BITS-1:0]])
      else $error("Removal of an absent index or from an empty heap.");

endmodule

[rtl/indexed_max_priority_queue.sv]
// ----------------------------------------------------------------------------
// Indexed max priority queue
// Binary max-heap over entry indices with insert, remove, extract and
// change-key requests.
// ----------------------------------------------------------------------------
// One request is worked at a time, and the next one is taken in the cycle after
// the result is loaded into the output register. A request first checks its
// entry index or the occupancy; if it passes, it updates the heap memories and
// restores the heap order by a sift where needed. On the way up, each level
// reads the parent's index, then its key, and swaps when the entry's key is
// greater. On the way down, each level reads the left child's index, then its
// key and the right child's index, then the right child's key, and swaps the
// entry with the larger child when that key beats the entry's. Each heap memory
// has one read port, and each key read depends on the index read before it. A
// new request is taken while the previous result still waits in the output
// register, but its own result is held back until that register is free.
module indexed_max_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [imq_pkg::OP_BITS-1:0]      req_op,
   input  logic [imq_pkg::IDX_BITS-1:0]     req_entry_index,
   input  logic [imq_pkg::REQ_KEY_BITS-1:0] req_priority_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [imq_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [imq_pkg::IDX_BITS-1:0]     rsp_result_index,
   output logic                             rsp_present,
   output logic                             rsp_is_empty,
   output logic [imq_pkg::CNT_BITS-1:0]     rsp_occupancy
);
   import imq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   imq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   imq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_entry_index  (req_entry_index),
      .req_priority_key (req_priority_key),
      .st               (st),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_present      (rsp_present),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
